/* rtl/unit_normal_from_cross_product_top_defines.svh */
// assertion helpers used by the checker file
`ifndef UNIT_NORMAL_FROM_CROSS_PRODUCT_TOP_DEFINES_SVH
`define UNIT_NORMAL_FROM_CROSS_PRODUCT_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while in reset
`define UNFCP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("unfcp check failed");

// next-cycle implication
`define UNFCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("unfcp check failed");

`endif

/* rtl/unfcp_pkg.sv */
package unfcp_pkg;

  // width of each output component
  localparam int OUT_WIDTH = 16;

  // defaults for the top level parameters
  localparam int COMPONENT_BITS_DEF = 16;
  localparam int FRACTION_BITS_DEF  = 14;

endpackage

/* rtl/unit_normal_from_cross_product_top.sv */
// Unit normal along the cross product of two signed integer 3D vectors a and b.
// One beat in carries a and b, one beat out carries n = c / |c| in signed
// Q1.FRACTION_BITS (c = a x b, exact), each component truncated toward zero.
// |c| is the floor integer square root of cx^2 + cy^2 + cz^2. When c is the
// zero vector the outputs are zero and degenerate_o is set. A new beat is
// taken every cycle while in_stall_o is low; the square root resolves one root
// bit per stage, and the divider resolves one quotient bit per stage.
// The whole pipeline advances together; a two-entry output (register plus
// skid) lets the pipeline keep taking beats while a result waits, and
// in_stall_o only rises once a result has gone into the skid entry, which
// happens only while the output is stalled.
module unit_normal_from_cross_product_top #(
  parameter int COMPONENT_BITS = unfcp_pkg::COMPONENT_BITS_DEF,
  parameter int FRACTION_BITS  = unfcp_pkg::FRACTION_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [COMPONENT_BITS-1:0]        ax_i,
  input  logic signed [COMPONENT_BITS-1:0]        ay_i,
  input  logic signed [COMPONENT_BITS-1:0]        az_i,
  input  logic signed [COMPONENT_BITS-1:0]        bx_i,
  input  logic signed [COMPONENT_BITS-1:0]        by_i,
  input  logic signed [COMPONENT_BITS-1:0]        bz_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [unfcp_pkg::OUT_WIDTH-1:0]  nx_o,
  output logic signed [unfcp_pkg::OUT_WIDTH-1:0]  ny_o,
  output logic signed [unfcp_pkg::OUT_WIDTH-1:0]  nz_o,
  output logic                                    degenerate_o
);

  localparam int OW = unfcp_pkg::OUT_WIDTH;
  localparam int CB = COMPONENT_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int PW = 2 * CB;         // product width
  localparam int CW = 2 * CB + 1;     // cross component width
  localparam int AW = 2 * CB;         // |c| width
  localparam int SW = 2 * AW + 2;     // sum of squares width
  localparam int RW = SW / 2;         // root width
  localparam int QW = F + 1;          // quotient width
  localparam int EW = (QW + 1 > OW) ? QW + 1 : OW;
  localparam logic [QW-1:0] QLim = {1'b1, {F{1'b0}}};

  // whole pipeline moves while the skid entry is empty
  logic en;
  logic skid_v_q;
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // stage 1: six products
  logic              v1_q;
  logic signed [PW-1:0] prod_q [6];

  // stage 2: cross product
  logic              v2_q;
  logic signed [CW-1:0] cross_q [3];

  // stage 3: magnitudes, signs, zero check
  logic              v3_q;
  logic [AW-1:0]     abs3_q [3];
  logic [2:0]        neg3_q;
  logic              deg3_q;

  // stage 4: squares
  logic              v4_q;
  logic [2*AW-1:0]   sq_q [3];
  logic [AW-1:0]     abs4_q [3];
  logic [2:0]        neg4_q;
  logic              deg4_q;

  // square root stages, index 0 holds the sum of squares
  logic              sv_q      [RW+1];
  logic [SW-1:0]     sr_rem_q  [RW+1];
  logic [RW-1:0]     sr_root_q [RW+1];
  logic [AW-1:0]     sr_abs_q  [RW+1][3];
  logic [2:0]        sr_neg_q  [RW+1];
  logic              sr_deg_q  [RW+1];

  // divider stages
  logic              dv_q     [F+1];
  logic [RW-1:0]     dr_rem_q [F+1][3];
  logic [QW-1:0]     dq_q     [F+1][3];
  logic [RW-1:0]     dm_q     [F+1];
  logic [2:0]        dneg_q   [F+1];
  logic              ddeg_q   [F+1];

  // tail register
  logic              tv_q;
  logic [OW-1:0]     tn_q [3];
  logic              tdeg_q;

  // output register and skid
  logic              out_v_q;
  logic [OW-1:0]     out_n_q [3];
  logic              out_deg_q;
  logic [OW-1:0]     skid_n_q [3];
  logic              skid_deg_q;

  // ---------------- front end ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      sv_q[0] <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      sv_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q[0] <= ay_i * bz_i;
      prod_q[1] <= az_i * by_i;
      prod_q[2] <= az_i * bx_i;
      prod_q[3] <= ax_i * bz_i;
      prod_q[4] <= ax_i * by_i;
      prod_q[5] <= ay_i * bx_i;
      for (int k = 0; k < 3; k++) begin
        cross_q[k] <= CW'(prod_q[2*k]) - CW'(prod_q[2*k+1]);
      end
      for (int k = 0; k < 3; k++) begin
        neg3_q[k] <= cross_q[k][CW-1];
        abs3_q[k] <= cross_q[k][CW-1] ? AW'(-cross_q[k]) : AW'(cross_q[k]);
      end
      deg3_q <= (cross_q[0] == '0) && (cross_q[1] == '0) && (cross_q[2] == '0);
      for (int k = 0; k < 3; k++) begin
        sq_q[k]   <= (2*AW)'(abs3_q[k]) * (2*AW)'(abs3_q[k]);
        abs4_q[k] <= abs3_q[k];
      end
      neg4_q <= neg3_q;
      deg4_q <= deg3_q;
      sr_rem_q[0]  <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
      sr_root_q[0] <= '0;
      for (int k = 0; k < 3; k++) begin
        sr_abs_q[0][k] <= abs4_q[k];
      end
      sr_neg_q[0] <= neg4_q;
      sr_deg_q[0] <= deg4_q;
    end
  end

  // ---------------- square root, one root bit per stage ----------------
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam int I = RW - 1 - j;
    logic [SW-1:0] trial;
    logic          fits;
    assign trial = (SW'(sr_root_q[j]) << (I + 1)) | (SW'(1) << (2 * I));
    assign fits  = sr_rem_q[j] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j+1] <= 1'b0;
      end else if (en) begin
        sv_q[j+1] <= sv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_rem_q[j+1]  <= fits ? sr_rem_q[j] - trial : sr_rem_q[j];
        sr_root_q[j+1] <= fits ? (sr_root_q[j] | (RW'(1) << I)) : sr_root_q[j];
        sr_abs_q[j+1]  <= sr_abs_q[j];
        sr_neg_q[j+1]  <= sr_neg_q[j];
        sr_deg_q[j+1]  <= sr_deg_q[j];
      end
    end
  end

  // ---------------- divider ----------------
  // first quotient bit: |c| against m, |c| never exceeds twice m
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= sv_q[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (RW'(sr_abs_q[RW][k]) >= sr_root_q[RW]) begin
          dr_rem_q[0][k] <= RW'(sr_abs_q[RW][k]) - sr_root_q[RW];
          dq_q[0][k]     <= QW'(1);
        end else begin
          dr_rem_q[0][k] <= RW'(sr_abs_q[RW][k]);
          dq_q[0][k]     <= '0;
        end
      end
      dm_q[0]   <= sr_root_q[RW];
      dneg_q[0] <= sr_neg_q[RW];
      ddeg_q[0] <= sr_deg_q[RW];
    end
  end

  // fraction bits, one per stage
  for (genvar t = 1; t <= F; t++) begin : g_div
    logic [RW:0] part [3];
    logic [2:0]  fits;
    for (genvar k = 0; k < 3; k++) begin : g_lane
      assign part[k] = {dr_rem_q[t-1][k], 1'b0};
      assign fits[k] = part[k] >= {1'b0, dm_q[t-1]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[t] <= 1'b0;
      end else if (en) begin
        dv_q[t] <= dv_q[t-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          dr_rem_q[t][k] <= fits[k] ? RW'(part[k] - {1'b0, dm_q[t-1]}) : RW'(part[k]);
          dq_q[t][k]     <= {dq_q[t-1][k][QW-2:0], fits[k]};
        end
        dm_q[t]   <= dm_q[t-1];
        dneg_q[t] <= dneg_q[t-1];
        ddeg_q[t] <= ddeg_q[t-1];
      end
    end
  end

  // ---------------- saturate, sign, tail ----------------
  logic [OW-1:0] fin_n [3];
  always_comb begin
    logic [QW-1:0] qs;
    logic [EW-1:0] sv;
    for (int k = 0; k < 3; k++) begin
      qs = (dq_q[F][k] > QLim) ? QLim : dq_q[F][k];
      sv = dneg_q[F][k] ? EW'(0) - EW'(qs) : EW'(qs);
      fin_n[k] = ddeg_q[F] ? '0 : sv[OW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= 1'b0;
    end else if (en) begin
      tv_q <= dv_q[F];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tn_q   <= fin_n;
      tdeg_q <= ddeg_q[F];
    end
  end

  // ---------------- output register and skid ----------------
  logic out_take;
  assign out_take = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_take) begin
      out_v_q  <= skid_v_q || tv_q;
      skid_v_q <= 1'b0;
    end else if (en && tv_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      if (skid_v_q) begin
        out_n_q   <= skid_n_q;
        out_deg_q <= skid_deg_q;
      end else begin
        out_n_q   <= tn_q;
        out_deg_q <= tdeg_q;
      end
    end else if (en && tv_q) begin
      skid_n_q   <= tn_q;
      skid_deg_q <= tdeg_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign nx_o         = out_n_q[0];
  assign ny_o         = out_n_q[1];
  assign nz_o         = out_n_q[2];
  assign degenerate_o = out_deg_q;

endmodule

/* rtl/unfcp_checker.sv */
`include "unit_normal_from_cross_product_top_defines.svh"

module unfcp_checker #(
  parameter int COMPONENT_BITS = unfcp_pkg::COMPONENT_BITS_DEF,
  parameter int FRACTION_BITS  = unfcp_pkg::FRACTION_BITS_DEF
) (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_valid_i,
  input logic                                    in_stall_o,
  input logic signed [COMPONENT_BITS-1:0]        ax_i,
  input logic signed [COMPONENT_BITS-1:0]        ay_i,
  input logic signed [COMPONENT_BITS-1:0]        az_i,
  input logic signed [COMPONENT_BITS-1:0]        bx_i,
  input logic signed [COMPONENT_BITS-1:0]        by_i,
  input logic signed [COMPONENT_BITS-1:0]        bz_i,
  input logic                                    out_valid_o,
  input logic                                    out_stall_i,
  input logic signed [unfcp_pkg::OUT_WIDTH-1:0]  nx_o,
  input logic signed [unfcp_pkg::OUT_WIDTH-1:0]  ny_o,
  input logic signed [unfcp_pkg::OUT_WIDTH-1:0]  nz_o,
  input logic                                    degenerate_o
);

  localparam int Lim = 1 << FRACTION_BITS;
  localparam int OW  = unfcp_pkg::OUT_WIDTH;

  // whole result beat and its range check
  logic [3*OW:0] out_beat;
  logic          in_unit;
  assign out_beat = {nx_o, ny_o, nz_o, degenerate_o};
  assign in_unit  = (int'(nx_o) <= Lim) && (int'(nx_o) >= -Lim) &&
                    (int'(ny_o) <= Lim) && (int'(ny_o) >= -Lim) &&
                    (int'(nz_o) <= Lim) && (int'(nz_o) >= -Lim);

  // a held result beat does not change
  `UNFCP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_beat))

  // degenerate beats carry a zero vector
  `UNFCP_ASSERT_NOW(a_deg_zero, out_valid_o && degenerate_o, nx_o == '0 && ny_o == '0 && nz_o == '0)

  // components stay within the unit
  `UNFCP_ASSERT_NOW(a_unit_range, out_valid_o, in_unit)

  // input side only backs up after a stalled output beat
  `UNFCP_ASSERT_NOW(a_stall_cause, $rose(in_stall_o), $past(out_valid_o && out_stall_i))

endmodule

bind unit_normal_from_cross_product_top unfcp_checker #(
  .COMPONENT_BITS(COMPONENT_BITS),
  .FRACTION_BITS (FRACTION_BITS)
) u_unfcp_checker (.*);

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int CB = unfcp_pkg::COMPONENT_BITS_DEF;
  localparam int FB = unfcp_pkg::FRACTION_BITS_DEF;
  localparam int OW = unfcp_pkg::OUT_WIDTH;
  localparam int LATENCY = 2 * CB + FB + 9;
  localparam int WATCHDOG_LIMIT = 20 * LATENCY + 400;
  localparam int N_RANDOM = 1950;

  typedef struct packed {
    logic signed [CB-1:0] ax, ay, az, bx, by, bz;
  } vec_pair_t;

  typedef struct packed {
    logic signed [OW-1:0] nx, ny, nz;
    logic                 degenerate;
  } normal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CB-1:0] ax_i = '0, ay_i = '0, az_i = '0, bx_i = '0, by_i = '0, bz_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [OW-1:0] nx_o, ny_o, nz_o;
  logic degenerate_o;

  unit_normal_from_cross_product_top uut (.*);

  always #6 clk_i = ~clk_i;

  vec_pair_t pending_pairs[$];
  normal_t   expected_normals[$];
  bit        stim_done = 1'b0;
  bit        quiet_tail = 1'b0;
  int        mismatches = 0;
  int        results_seen = 0;
  int        degenerate_seen = 0;
  int        idle_cycles = 0;
  int        send_gap = 0;
  int        recv_gap = 0;

  // floor square root of a 99-bit sum, one root bit at a time
  function automatic logic [48:0] floor_root(logic [98:0] s);
    logic [48:0] r;
    r = '0;
    for (int i = 48; i >= 0; i--) begin
      r[i] = 1'b1;
      if ({50'b0, r} * {50'b0, r} > s) r[i] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic signed [OW-1:0] scale_to_unit(longint c, logic [48:0] m);
    logic [63:0] mag, q;
    mag = (c < 0) ? -c : c;
    q = (mag << FB) / m;
    if (q > (64'd1 << FB)) q = 64'd1 << FB;
    if (c < 0) q = -q;
    return q[OW-1:0];
  endfunction

  function automatic normal_t predict_normal(vec_pair_t p);
    normal_t n;
    longint cx, cy, cz;
    logic [98:0] sq;
    logic [48:0] m;
    cx = longint'(p.ay) * p.bz - longint'(p.az) * p.by;
    cy = longint'(p.az) * p.bx - longint'(p.ax) * p.bz;
    cz = longint'(p.ax) * p.by - longint'(p.ay) * p.bx;
    n = '0;
    if (cx == 0 && cy == 0 && cz == 0) begin
      n.degenerate = 1'b1;
      return n;
    end
    sq = 99'(cx * cx) + 99'(cy * cy) + 99'(cz * cz);
    m = floor_root(sq);
    if (m == 0) m = 1;
    n.nx = scale_to_unit(cx, m);
    n.ny = scale_to_unit(cy, m);
    n.nz = scale_to_unit(cz, m);
    return n;
  endfunction

  function automatic vec_pair_t make_pair(int ax, int ay, int az, int bx, int by, int bz);
    vec_pair_t p;
    p.ax = CB'(ax); p.ay = CB'(ay); p.az = CB'(az);
    p.bx = CB'(bx); p.by = CB'(by); p.bz = CB'(bz);
    return p;
  endfunction

  function automatic logic signed [CB-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return CB'($urandom_range(0, 8) - 4);
      2: return CB'($urandom_range(0, 200) - 100);
      default: return CB'($urandom);
    endcase
  endfunction

  // driver: holds the beat while stalled, bursts of idling between beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          vec_pair_t p;
          p = pending_pairs.pop_front();
          {ax_i, ay_i, az_i, bx_i, by_i, bz_i} <= p;
          expected_normals.push_back(predict_normal(p));
          in_valid_i <= 1'b1;
          if (!quiet_tail && $urandom_range(0, 15) == 0) send_gap <= $urandom_range(1, 19);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 12) == 0) begin
        recv_gap <= $urandom_range(0, 18);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (degenerate_o) degenerate_seen++;
      if (expected_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        normal_t e;
        e = expected_normals.pop_front();
        if (nx_o !== e.nx || ny_o !== e.ny || nz_o !== e.nz || degenerate_o !== e.degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected n=(%0d,%0d,%0d) deg=%0b got n=(%0d,%0d,%0d) deg=%0b",
                     e.nx, e.ny, e.nz, e.degenerate, nx_o, ny_o, nz_o, degenerate_o);
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else if (rst_ni && !stim_done) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", expected_normals.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int tail;
    // directed: extremes, degenerate cases, axis-aligned normals
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(1, 2, 3, 2, 4, 6));
    pending_pairs.push_back(make_pair(5, -7, 9, 0, 0, 0));
    pending_pairs.push_back(make_pair(1, 0, 0, 0, 1, 0));
    pending_pairs.push_back(make_pair(0, 1, 0, 1, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 1, 1, 0, 0));
    pending_pairs.push_back(make_pair(-32768, -32768, -32768, 32767, 32767, -32768));
    pending_pairs.push_back(make_pair(-32768, 0, 0, 0, -32768, 0));
    pending_pairs.push_back(make_pair(32767, -32768, 32767, -32768, 32767, -32768));
    pending_pairs.push_back(make_pair(-32768, 32767, 0, 0, -32768, 32767));
    pending_pairs.push_back(make_pair(32767, 32767, 32767, -32768, -32768, -32768));
    pending_pairs.push_back(make_pair(1, 1, 0, 1, 0, 0));
    pending_pairs.push_back(make_pair(1, 1, 1, -1, 1, 0));
    pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1));
    pending_pairs.push_back(make_pair(3, 0, 0, 0, 4, 0));
    pending_pairs.push_back(make_pair(32767, 1, 0, 1, 32767, 0));
    pending_pairs.push_back(make_pair(-21846, 21845, -1, 12345, -54, 32767));
    // random, with some deliberately parallel pairs
    for (int i = 0; i < N_RANDOM; i++) begin
      vec_pair_t p;
      p.ax = rand_comp(); p.ay = rand_comp(); p.az = rand_comp();
      p.bx = rand_comp(); p.by = rand_comp(); p.bz = rand_comp();
      if ($urandom_range(0, 19) == 0) begin
        int k;
        k = $urandom_range(0, 6) - 3;
        p.ax = CB'($urandom_range(0, 2000) - 1000);
        p.ay = CB'($urandom_range(0, 2000) - 1000);
        p.az = CB'($urandom_range(0, 2000) - 1000);
        p.bx = CB'(p.ax * k); p.by = CB'(p.ay * k); p.bz = CB'(p.az * k);
      end
      pending_pairs.push_back(p);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // last part of the run goes at full rate on both sides
    wait (pending_pairs.size() < 200);
    quiet_tail = 1'b1;
    wait (pending_pairs.size() == 0 && in_valid_i && !in_stall_o);
    @(posedge clk_i);
    wait (expected_normals.size() == 0);
    stim_done = 1'b1;
    tail = 0;
    while (tail < LATENCY + 10) begin
      @(posedge clk_i);
      tail++;
    end
    $display("checked %0d normals, %0d of them degenerate, with random stalls on both sides",
             results_seen, degenerate_seen);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
